/* design/smmac_pkg.sv */
// shared types and constants for the square matrix row multiply-accumulate block
// no dependencies
`default_nettype none

package smmac_pkg;

    localparam int MAX_SIZE_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int SUM_W          = 48;
    localparam int IDX_W          = 6;
    localparam int SIZE_W         = 7;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_LOAD_C  = 2'd2;
    localparam logic [1:0] MODE_COMPUTE = 2'd3;

    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RST = 7'd64;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic issue;
        logic load_acc;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COL,
        ST_RUN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

/* design/smmac_ram.sv */
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module smmac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/smmac_mac.sv */
// shared multiply-accumulate unit: registered product, saturating 48-bit accumulator
// depends on smmac_pkg
`default_nettype none

module smmac_mac
    import smmac_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_mac_ctl                     i_ctl,
    input  wire logic signed [ELEM_WIDTH-1:0] i_a,
    input  wire logic signed [ELEM_WIDTH-1:0] i_b,
    input  wire logic signed [SUM_W-1:0]      i_c,
    output logic signed [SUM_W-1:0]           o_acc,
    output logic                              o_busy
);

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SW     = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    logic                     r_s1_valid;
    logic                     r_prod_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SW-1:0]     sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    always_comb begin
        sum_wide = {{(SW-SUM_W){r_acc[SUM_W-1]}}, r_acc}
                 + {{(SW-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        // fits when all bits above the 48-bit sign agree
        if (sum_wide[SW-1:SUM_W-1] == {(SW-SUM_W+1){1'b0}}
            || sum_wide[SW-1:SUM_W-1] == {(SW-SUM_W+1){1'b1}}) begin
            sum_sat = sum_wide[SUM_W-1:0];
        end else if (sum_wide[SW-1]) begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            r_s1_valid   <= i_ctl.issue;
            r_prod_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        if (i_ctl.load_acc) begin
            r_acc <= i_c;
        end else if (r_prod_valid) begin
            r_acc <= sum_sat;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_s1_valid | r_prod_valid;

endmodule

`default_nettype wire

/* design/smmac_ctrl.sv */
// sequencer: element loads, column and k loops, write-back and output register
// depends on smmac_pkg
`default_nettype none

module smmac_ctrl
    import smmac_pkg::*;
#(
    parameter int MAX_SIZE   = MAX_SIZE_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [SIZE_W-1:0]                  i_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire t_in_item                           i_in_item,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output t_out_item                               o_out_item,
    output logic                                    o_a_we,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]    o_a_addr,
    output logic                                    o_b_we,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]    o_b_addr,
    output logic [ELEM_WIDTH-1:0]                   o_ab_wdata,
    output logic                                    o_c_we,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]    o_c_addr,
    output logic [SUM_W-1:0]                        o_c_wdata,
    output t_mac_ctl                                o_mac_ctl,
    input  wire logic signed [SUM_W-1:0]            i_acc,
    input  wire logic                               i_mac_busy
);

    localparam int ADDR_W = $clog2(MAX_SIZE * MAX_SIZE);
    localparam logic [8:0] MAX_CMP = 9'(MAX_SIZE);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [SIZE_W-1:0]  r_n, n_n;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [ADDR_W-1:0]  r_b_addr, n_b_addr;
    logic               r_first, n_first;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               accept;
    logic               load_ok;
    logic [ADDR_W-1:0]  load_addr;
    logic               last_k;
    logic               last_j;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_row_base <= n_row_base;
        r_n        <= n_n;
        r_j        <= n_j;
        r_k        <= n_k;
        r_b_addr   <= n_b_addr;
        r_first    <= n_first;
        r_out_item <= n_out_item;
    end

    always_comb begin
        accept    = i_in_valid && (r_state == ST_IDLE);
        load_ok   = ({3'b000, i_in_item.row} < MAX_CMP) && ({3'b000, i_in_item.col} < MAX_CMP);
        load_addr = ADDR_W'(i_in_item.row) * ADDR_W'(MAX_SIZE) + ADDR_W'(i_in_item.col);
        last_k    = ({1'b0, r_k} == (r_n - 7'd1));
        last_j    = ({1'b0, r_j} == (r_n - 7'd1));
        out_free  = !r_out_valid || i_out_ready;

        n_state     = r_state;
        n_row       = r_row;
        n_row_base  = r_row_base;
        n_n         = r_n;
        n_j         = r_j;
        n_k         = r_k;
        n_b_addr    = r_b_addr;
        n_first     = r_first;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && !i_out_ready;

        o_a_we     = 1'b0;
        o_b_we     = 1'b0;
        o_c_we     = 1'b0;
        o_a_addr   = r_row_base + ADDR_W'(r_k);
        o_b_addr   = r_b_addr;
        o_c_addr   = r_row_base + ADDR_W'(r_j);
        o_ab_wdata = i_in_item.value[ELEM_WIDTH-1:0];
        o_c_wdata  = i_in_item.value;
        o_mac_ctl  = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_item.mode == MODE_COMPUTE) begin
                        if ({1'b0, i_in_item.row} < i_n) begin
                            n_row      = i_in_item.row;
                            n_row_base = ADDR_W'(i_in_item.row) * ADDR_W'(MAX_SIZE);
                            n_n        = i_n;
                            n_j        = '0;
                            n_state    = ST_COL;
                        end
                    end else if (load_ok) begin
                        o_a_addr = load_addr;
                        o_b_addr = load_addr;
                        o_c_addr = load_addr;
                        o_a_we   = (i_in_item.mode == MODE_LOAD_A);
                        o_b_we   = (i_in_item.mode == MODE_LOAD_B);
                        o_c_we   = (i_in_item.mode == MODE_LOAD_C);
                    end
                end
            end
            ST_COL: begin
                // c entry read issued here, lands for the first run cycle
                n_k      = '0;
                n_b_addr = ADDR_W'(r_j);
                n_first  = 1'b1;
                n_state  = ST_RUN;
            end
            ST_RUN: begin
                o_mac_ctl.issue    = 1'b1;
                o_mac_ctl.load_acc = r_first;
                n_first  = 1'b0;
                n_k      = r_k + 6'd1;
                n_b_addr = r_b_addr + ADDR_W'(MAX_SIZE);
                if (last_k) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_mac_busy && out_free) begin
                    o_c_we      = 1'b1;
                    o_c_wdata   = i_acc;
                    n_out_valid = 1'b1;
                    n_out_item.out_row = r_row;
                    n_out_item.out_col = r_j;
                    n_out_item.sum     = i_acc;
                    n_out_item.last    = last_j;
                    n_j = r_j + 6'd1;
                    n_state = last_j ? ST_IDLE : ST_COL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* design/square_matrix_row_multiply_accumulate_top.sv */
// top level: apb register, three element stores, sequencer and shared mac
// depends on smmac_pkg, smmac_ram, smmac_mac, smmac_ctrl
//
// input items (valid/ready) load one element of a, b or c, or ask for one row
// of c += a * b over the n x n corner, n set by the matrix_size register (apb
// address 0, reset 64; 0 acts as 1, values above the store size are capped).
// a load gives no result. a compute item gives one result item per column, the
// final column flagged last; a row outside n gives none. each column takes one c
// read, n issues into the single multiply-accumulate unit (one a and one b read
// per cycle), a pipeline drain and one write-back. the input is not ready while
// a row is in progress. results leave through an output register; a stalled
// receiver holds the sequencer at the write-back of the next column, and a new
// item is taken while the last result still waits. reset clears control state
// and the size register only; stores are undefined until written, no clearing
// pass.
`default_nettype none

module square_matrix_row_multiply_accumulate_top
    import smmac_pkg::*;
#(
    parameter int MAX_SIZE   = MAX_SIZE_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_CAP = (MAX_SIZE < 64) ? SIZE_W'(MAX_SIZE) : 7'd64;

    logic [SIZE_W-1:0]         r_matrix_size;
    logic [SIZE_W-1:0]         n_use;

    logic                      a_we, b_we, c_we;
    logic [ADDR_W-1:0]         a_addr, b_addr, c_addr;
    logic [ELEM_WIDTH-1:0]     ab_wdata;
    logic [SUM_W-1:0]          c_wdata;
    logic [ELEM_WIDTH-1:0]     a_rdata, b_rdata;
    logic [SUM_W-1:0]          c_rdata;
    t_mac_ctl                  mac_ctl;
    logic signed [SUM_W-1:0]   acc;
    logic                      mac_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MATRIX_SIZE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE)) begin
            r_matrix_size <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_MATRIX_SIZE) begin
            prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_matrix_size};
        end else begin
            prdata = '0;
        end
        if (r_matrix_size == '0) begin
            n_use = 7'd1;
        end else if (r_matrix_size > SIZE_CAP) begin
            n_use = SIZE_CAP;
        end else begin
            n_use = r_matrix_size;
        end
    end

    assign pready = 1'b1;

    smmac_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_left_store (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_addr  (a_addr),
        .i_wdata (ab_wdata),
        .o_rdata (a_rdata)
    );

    smmac_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_right_store (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_addr  (b_addr),
        .i_wdata (ab_wdata),
        .o_rdata (b_rdata)
    );

    smmac_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_accum_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (c_rdata)
    );

    smmac_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .i_c     (c_rdata),
        .o_acc   (acc),
        .o_busy  (mac_busy)
    );

    smmac_ctrl #(.MAX_SIZE(MAX_SIZE), .ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (n_use),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_a_we      (a_we),
        .o_a_addr    (a_addr),
        .o_b_we      (b_we),
        .o_b_addr    (b_addr),
        .o_ab_wdata  (ab_wdata),
        .o_c_we      (c_we),
        .o_c_addr    (c_addr),
        .o_c_wdata   (c_wdata),
        .o_mac_ctl   (mac_ctl),
        .i_acc       (acc),
        .i_mac_busy  (mac_busy)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_square_matrix_row_multiply_accumulate_top.sv */
// self-checking testbench for square_matrix_row_multiply_accumulate_top
// keeps its own copy of a, b, c and the size register and predicts every result item
// depends on smmac_pkg and the design files
`timescale 1ns / 100ps

module tb_square_matrix_row_multiply_accumulate_top;
    import smmac_pkg::*;

    localparam int          STORE_CELLS  = MAX_SIZE_DEF * MAX_SIZE_DEF;
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam longint      SAT_HI       = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint      SAT_LO       = -SAT_HI - 1;
    localparam logic [PADDR_W-1:0] SIZE_ADDR = PADDR_W'({REG_MATRIX_SIZE, 2'b00});

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    t_in_item           in_item;
    logic               out_ready;
    logic               apb_sel;
    logic               apb_enable;
    logic               apb_write;
    logic [PADDR_W-1:0] apb_addr;
    logic [PDATA_W-1:0] apb_wdata;

    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // mirror of the block state
    logic signed [ELEM_WIDTH_DEF-1:0] a_elem [STORE_CELLS];
    logic signed [ELEM_WIDTH_DEF-1:0] b_elem [STORE_CELLS];
    logic signed [SUM_W-1:0]          c_elem [STORE_CELLS];
    bit                               a_set  [STORE_CELLS];
    bit                               b_set  [STORE_CELLS];
    bit                               c_set  [STORE_CELLS];
    logic [SIZE_W-1:0]                size_reg;

    t_out_item   pending_row_results [$];
    int unsigned mismatches;
    int unsigned items_sent;
    bit          no_idle;
    bit          hold_request;

    square_matrix_row_multiply_accumulate_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .psel        (apb_sel),
        .penable     (apb_enable),
        .pwrite      (apb_write),
        .paddr       (apb_addr),
        .pwdata      (apb_wdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_size();
        int unsigned n;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
        return n;
    endfunction

    // update the mirror with one accepted item and queue the row it produces
    function automatic void apply_item(input t_in_item item);
        int unsigned n;
        int          idx;
        longint      acc;
        t_out_item   res;
        idx = item.row * MAX_SIZE_DEF + item.col;
        if (item.mode == MODE_LOAD_A) begin
            a_elem[idx] = item.value[ELEM_WIDTH_DEF-1:0];
            a_set[idx]  = 1'b1;
        end else if (item.mode == MODE_LOAD_B) begin
            b_elem[idx] = item.value[ELEM_WIDTH_DEF-1:0];
            b_set[idx]  = 1'b1;
        end else if (item.mode == MODE_LOAD_C) begin
            c_elem[idx] = item.value;
            c_set[idx]  = 1'b1;
        end else begin
            n = active_size();
            if (item.row >= n) return;
            for (int j = 0; j < n; j++) begin
                acc = c_elem[item.row * MAX_SIZE_DEF + j];
                for (int k = 0; k < n; k++) begin
                    acc = acc + longint'(a_elem[item.row * MAX_SIZE_DEF + k])
                              * longint'(b_elem[k * MAX_SIZE_DEF + j]);
                    // saturate after every product
                    if (acc > SAT_HI) acc = SAT_HI;
                    if (acc < SAT_LO) acc = SAT_LO;
                end
                c_elem[item.row * MAX_SIZE_DEF + j] = acc[SUM_W-1:0];
                res.out_row = item.row;
                res.out_col = IDX_W'(j);
                res.sum     = acc[SUM_W-1:0];
                res.last    = (j == n - 1);
                pending_row_results.push_back(res);
            end
        end
    endfunction

    function automatic logic [SUM_W-1:0] rand_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return r[SUM_W-1:0];
            1: return SUM_W'(SAT_HI);
            2: return SUM_W'(SAT_LO);
            3: return SUM_W'($signed(r[10:0]));
            4: return {r[SUM_W-1:16], 16'h7fff};
            default: return {r[SUM_W-1:16], 16'h8000};
        endcase
    endfunction

    task automatic send_item(input t_in_item item);
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!o_in_ready);
        apply_item(item);
        items_sent++;
    endtask

    task automatic load(input logic [1:0] mode, input int unsigned r, input int unsigned c,
                        input logic [SUM_W-1:0] value);
        t_in_item item;
        item.mode  = mode;
        item.row   = IDX_W'(r);
        item.col   = IDX_W'(c);
        item.value = value;
        send_item(item);
    endtask

    task automatic compute_row(input int unsigned r);
        load(MODE_COMPUTE, r, $urandom_range(0, MAX_SIZE_DEF - 1), rand_value());
    endtask

    // write every entry that row r reads at size n and that is still unknown
    task automatic prepare_row(input int unsigned r, input int unsigned n);
        for (int k = 0; k < n; k++)
            if (!a_set[r * MAX_SIZE_DEF + k]) load(MODE_LOAD_A, r, k, rand_value());
        for (int j = 0; j < n; j++)
            if (!c_set[r * MAX_SIZE_DEF + j]) load(MODE_LOAD_C, r, j, rand_value());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < n; j++)
                if (!b_set[k * MAX_SIZE_DEF + j]) load(MODE_LOAD_B, k, j, rand_value());
    endtask

    // sender pause: all results in, then room for a compute that gives none
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_row_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [SIZE_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= wr;
        apb_addr   <= SIZE_ADDR;
        apb_wdata  <= PDATA_W'(wdata);
        @(posedge clk);
        apb_enable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_check(input logic [SIZE_W-1:0] expected);
        logic [PDATA_W-1:0] rdata;
        cfg_access(1'b0, '0, rdata);
        if (rdata[SIZE_W-1:0] !== expected) begin
            if (mismatches < 10)
                $display("matrix_size readback: expected %0d, got %0d", expected,
                         rdata[SIZE_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic cfg_set_size(input logic [SIZE_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        settle();
        cfg_access(1'b1, value, rdata);
        size_reg = value;
        cfg_check(value);
    endtask

    task automatic test_reset_value();
        cfg_check(MATRIX_SIZE_RST);
    endtask

    // saturation at both rails, recovery after a clipped step, ignored upper bits
    task automatic test_saturation();
        cfg_set_size(7'd2);
        load(MODE_LOAD_A, 0, 0, 48'habcd_0000_7fff);
        load(MODE_LOAD_A, 0, 1, 48'h0000_1234_8000);
        load(MODE_LOAD_B, 0, 0, 48'h0000_0000_7fff);
        load(MODE_LOAD_B, 1, 0, 48'hffff_ffff_7fff);
        load(MODE_LOAD_B, 0, 1, 48'h8000_0000_8000);
        load(MODE_LOAD_B, 1, 1, 48'h0000_0000_8000);
        load(MODE_LOAD_C, 0, 0, SUM_W'(SAT_HI));
        load(MODE_LOAD_C, 0, 1, SUM_W'(SAT_LO));
        compute_row(0);
        load(MODE_LOAD_A, 1, 0, 48'h0000_0000_8000);
        load(MODE_LOAD_A, 1, 1, 48'h7fff_ffff_8000);
        load(MODE_LOAD_C, 1, 0, '0);
        load(MODE_LOAD_C, 1, 1, '1);
        compute_row(1);
        compute_row(0);
        compute_row(2);
        load(MODE_LOAD_C, 63, 63, rand_value());
    endtask

    // size 0 acts as 1, rows beyond the size give nothing
    task automatic test_size_edges();
        cfg_set_size(7'd0);
        prepare_row(0, 1);
        compute_row(0);
        compute_row(1);
        compute_row(63);
        cfg_set_size(7'd1);
        compute_row(0);
        compute_row(5);
    endtask

    // long receiver stall so the block backs up into the input side
    task automatic test_backpressure();
        cfg_set_size(7'd4);
        prepare_row(0, 4);
        prepare_row(1, 4);
        settle();
        hold_request = 1'b1;
        compute_row(1);
        compute_row(0);
        load(MODE_LOAD_A, 2, 3, rand_value());
        compute_row(1);
        settle();
    endtask

    // sizes above the store size and the full size itself read back as written
    task automatic test_full_size();
        cfg_set_size(7'd127);
        cfg_set_size(7'd64);
    endtask

    task automatic random_phase(input logic [SIZE_W-1:0] size_cfg, input int unsigned n_items);
        int unsigned n;
        int unsigned start;
        int unsigned r;
        int unsigned k;
        int unsigned j;
        cfg_set_size(size_cfg);
        n = active_size();
        start = items_sent;
        while (items_sent - start < n_items) begin
            repeat ($urandom_range(0, 2))
                load(2'($urandom_range(MODE_LOAD_A, MODE_LOAD_C)),
                     $urandom_range(0, MAX_SIZE_DEF - 1), $urandom_range(0, MAX_SIZE_DEF - 1),
                     rand_value());
            if (n < MAX_SIZE_DEF && $urandom_range(0, 7) == 0) begin
                compute_row($urandom_range(n, MAX_SIZE_DEF - 1));
            end else begin
                r = $urandom_range(0, n - 1);
                prepare_row(r, n);
                repeat ($urandom_range(0, 3)) begin
                    k = $urandom_range(0, n - 1);
                    j = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 2))
                        0: load(MODE_LOAD_A, r, k, rand_value());
                        1: load(MODE_LOAD_B, k, j, rand_value());
                        default: load(MODE_LOAD_C, r, j, rand_value());
                    endcase
                end
                compute_row(r);
            end
        end
    endtask

    task automatic test_random();
        random_phase(7'd3, 14);
        random_phase(7'd6, 14);
        random_phase(7'd2, 14);
        random_phase(7'd5, 14);
        no_idle = 1'b1;
        random_phase(7'd4, 14);
    endtask

    task automatic finish_run();
        in_valid <= 1'b0;
        while (pending_row_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_row_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    endtask

    initial begin
        mismatches   = 0;
        items_sent   = 0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        size_reg     = MATRIX_SIZE_RST;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        apb_sel      <= 1'b0;
        apb_enable   <= 1'b0;
        apb_write    <= 1'b0;
        apb_addr     <= '0;
        apb_wdata    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_value();
        test_saturation();
        test_size_edges();
        test_backpressure();
        test_full_size();
        test_random();
        finish_run();
    end

    // receiver pacing: random stall bursts, plus one long hold on request
    initial begin : sink_pacing
        int unsigned run_left;
        int unsigned hold_left;
        bit          stalling;
        run_left  = 0;
        hold_left = 0;
        stalling  = 1'b0;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                if (run_left == 0) begin
                    stalling = !no_idle && ($urandom_range(0, 3) == 0);
                    run_left = stalling ? $urandom_range(1, 11) : $urandom_range(1, 20);
                end
                out_ready <= !stalling;
                run_left--;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_out_item exp_item;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_row_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result item: row %0d col %0d sum %0d last %0b",
                             o_out_item.out_row, o_out_item.out_col, o_out_item.sum,
                             o_out_item.last);
                mismatches++;
            end else begin
                exp_item = pending_row_results.pop_front();
                if (o_out_item.out_row !== exp_item.out_row
                    || o_out_item.out_col !== exp_item.out_col
                    || o_out_item.sum !== exp_item.sum
                    || o_out_item.last !== exp_item.last) begin
                    if (mismatches < 10)
                        $display("mismatch: expected row %0d col %0d sum %0d last %0b, got row %0d col %0d sum %0d last %0b",
                                 exp_item.out_row, exp_item.out_col, exp_item.sum,
                                 exp_item.last, o_out_item.out_row, o_out_item.out_col,
                                 o_out_item.sum, o_out_item.last);
                    mismatches++;
                end
            end
        end
    end

    // ends the run when no handshake completes for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (apb_sel && apb_enable))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
